/* hw/rtl/sct_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and constants of the source code tokenizer.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam logic [3:0] K_INT = 4'd0;
    localparam logic [3:0] K_STR = 4'd1;
    localparam logic [3:0] K_CHR = 4'd2;
    localparam logic [3:0] K_IDENT = 4'd3;
    localparam logic [3:0] K_KEYWORD = 4'd4;
    localparam logic [3:0] K_OPER = 4'd5;
    localparam logic [3:0] K_DELIM = 4'd6;
    localparam logic [3:0] K_ERROR = 4'd7;
    localparam logic [3:0] K_END = 4'd8;

    localparam logic [2:0] E_NONE = 3'd0;
    localparam logic [2:0] E_BADNUM = 3'd1;
    localparam logic [2:0] E_UNKNOWN = 3'd2;
    localparam logic [2:0] E_OPENSTR = 3'd3;
    localparam logic [2:0] E_OPENCHR = 3'd4;
    localparam logic [2:0] E_OPENCOMM = 3'd5;

    localparam int KW_COUNT = 26;
    localparam int KW_TEXT_LEN = 9;

    // One token descriptor.
    typedef struct packed {
        logic [3:0]  kind;
        logic [2:0]  err;
        logic [4:0]  kw;
        logic [7:0]  c1;
        logic [7:0]  c2;
        logic [23:0] line;
        logic [15:0] col;
        logic [31:0] off;
        logic [15:0] len;
        logic        last;
    } t_token;

    // What the front end hands the back end for one item.
    typedef struct packed {
        logic [1:0] count;
        t_token     t0;
        t_token     t1;
        t_token     t2;
    } t_group;

    function automatic logic [3:0] kw_len(input logic [4:0] k);
        case (k)
            5'd0: kw_len = 4'd2;
            5'd1: kw_len = 4'd4;
            5'd2: kw_len = 4'd3;
            5'd3: kw_len = 4'd5;
            5'd4: kw_len = 4'd6;
            5'd5: kw_len = 4'd3;
            5'd6: kw_len = 4'd6;
            5'd7: kw_len = 4'd5;
            5'd8: kw_len = 4'd4;
            5'd9: kw_len = 4'd4;
            5'd10: kw_len = 4'd4;
            5'd11: kw_len = 4'd5;
            5'd12: kw_len = 4'd6;
            5'd13: kw_len = 4'd6;
            5'd14: kw_len = 4'd7;
            5'd15: kw_len = 4'd9;
            5'd16: kw_len = 4'd7;
            5'd17: kw_len = 4'd8;
            5'd18: kw_len = 4'd5;
            5'd19: kw_len = 4'd6;
            5'd20: kw_len = 4'd5;
            5'd21: kw_len = 4'd9;
            5'd22: kw_len = 4'd3;
            5'd23: kw_len = 4'd6;
            5'd24: kw_len = 4'd4;
            5'd25: kw_len = 4'd5;
            default: kw_len = 4'd0;
        endcase
    endfunction

    function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [3:0] j);
        logic [8*KW_TEXT_LEN-1:0] s;
        case (k)
            5'd0: s = "if";
            5'd1: s = "else";
            5'd2: s = "for";
            5'd3: s = "while";
            5'd4: s = "return";
            5'd5: s = "int";
            5'd6: s = "double";
            5'd7: s = "float";
            5'd8: s = "char";
            5'd9: s = "bool";
            5'd10: s = "void";
            5'd11: s = "class";
            5'd12: s = "struct";
            5'd13: s = "public";
            5'd14: s = "private";
            5'd15: s = "protected";
            5'd16: s = "virtual";
            5'd17: s = "override";
            5'd18: s = "const";
            5'd19: s = "static";
            5'd20: s = "using";
            5'd21: s = "namespace";
            5'd22: s = "new";
            5'd23: s = "delete";
            5'd24: s = "true";
            5'd25: s = "false";
            default: s = '0;
        endcase
        // String constants sit at the low end; move the first letter to the top.
        s = s << (8 * (KW_TEXT_LEN - 32'(kw_len(k))));
        kw_char = s[8*(KW_TEXT_LEN-1-32'(j)) +: 8];
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/sct_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_front
// Scanner: classifies each byte and builds up to three descriptors per item.
// ----------------------------------------------------------------------------
module sct_front #(
    parameter int KEYWORD_MAX_LEN = 9
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [23:0]   i_cfg_data,
    input  wire logic          i_take,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_has,
    input  wire logic          i_eos,
    output sct_pkg::t_group    o_group
);
    import sct_pkg::*;

    localparam int NW = $clog2(KEYWORD_MAX_LEN);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_NUM    = 13'b0000000000010,
        S_BADNUM = 13'b0000000000100,
        S_IDENT  = 13'b0000000001000,
        S_OP     = 13'b0000000010000,
        S_LCOMM  = 13'b0000000100000,
        S_BCOMM  = 13'b0000001000000,
        S_BSTAR  = 13'b0000010000000,
        S_STR    = 13'b0000100000000,
        S_STRESC = 13'b0001000000000,
        S_CHR    = 13'b0010000000000,
        S_CHRESC = 13'b0100000000000,
        S_DEAD   = 13'b1000000000000
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [7:0]  r_pend, n_pend;
    logic [23:0] r_start, n_start;
    logic [23:0] r_line, n_line, r_sline, n_sline;
    logic [15:0] r_col, n_col, r_scol, n_scol;
    logic [31:0] r_off, n_off, r_soff, n_soff;
    logic [15:0] r_len, n_len;
    logic        r_fresh, n_fresh;
    logic [7:0]  r_name [KEYWORD_MAX_LEN];
    logic        name_we;
    logic [NW-1:0] name_idx;

    t_token      toks [3];
    logic [1:0]  cnt;

    function automatic logic is_dig(input logic [7:0] b);
        is_dig = b >= "0" && b <= "9";
    endfunction
    function automatic logic is_alp(input logic [7:0] b);
        is_alp = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    // Keyword lookup on the stored name and current length.
    logic [4:0] kw_hit;
    always_comb begin
        logic m;
        kw_hit = '0;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            m = (16'(kw_len(5'(i))) == r_len);
            for (int j = 0; j < KEYWORD_MAX_LEN; j++) begin
                if (j < KW_TEXT_LEN && 4'(j) < kw_len(5'(i))
                        && r_name[j] != kw_char(5'(i), 4'(j))) m = 1'b0;
            end
            if (m) kw_hit = 5'(i + 1);
        end
    end

    always_comb begin
        logic [7:0] b, p;
        logic fresh, clean;
        t_token t;
        logic [7:0] nm [KEYWORD_MAX_LEN];
        logic [4:0] hit;
        logic m;
        n_mode = r_mode; n_pend = r_pend; n_start = r_start;
        n_line = r_line; n_col = r_col; n_off = r_off;
        n_sline = r_sline; n_scol = r_scol; n_soff = r_soff;
        n_len = r_len; n_fresh = r_fresh;
        name_we = 1'b0; name_idx = '0;
        cnt = '0;
        b = i_byte; p = r_pend; fresh = 1'b0; clean = 1'b1;
        t = '0;
        hit = '0; m = 1'b0;
        for (int j = 0; j < KEYWORD_MAX_LEN; j++) nm[j] = '0;
        for (int k = 0; k < 3; k++) toks[k] = '0;
        if (i_cfg_we) begin
            n_start = i_cfg_data;
            if (r_fresh) n_line = i_cfg_data;
        end
        if (i_take && i_has) begin
            case (r_mode)
                S_DEAD: ;
                S_NUM: begin
                    if (is_dig(b)) n_len = (r_len == 16'hFFFF) ? r_len : r_len + 16'd1;
                    else if (is_alp(b)) begin
                        n_len = (r_len == 16'hFFFF) ? r_len : r_len + 16'd1;
                        n_mode = S_BADNUM;
                    end else begin
                        t = '0; t.kind = K_INT; toks[cnt] = t; cnt = cnt + 2'd1;
                        fresh = 1'b1;
                    end
                end
                S_BADNUM: begin
                    if (is_dig(b) || is_alp(b))
                        n_len = (r_len == 16'hFFFF) ? r_len : r_len + 16'd1;
                    else begin
                        t = '0; t.kind = K_ERROR; t.err = E_BADNUM;
                        toks[cnt] = t; cnt = cnt + 2'd1; n_mode = S_DEAD;
                    end
                end
                S_IDENT: begin
                    if (is_dig(b) || is_alp(b)) begin
                        if (r_len < 16'(KEYWORD_MAX_LEN)) begin
                            name_we = 1'b1; name_idx = NW'(r_len);
                        end
                        n_len = (r_len == 16'hFFFF) ? r_len : r_len + 16'd1;
                    end else begin
                        t = '0;
                        if (kw_hit != 0) begin t.kind = K_KEYWORD; t.kw = kw_hit; end
                        else t.kind = K_IDENT;
                        toks[cnt] = t; cnt = cnt + 2'd1; fresh = 1'b1;
                    end
                end
                S_OP: begin
                    n_pend = '0;
                    if (p == "/" && b == "/") begin
                        n_len = r_len + 16'd1; n_mode = S_LCOMM;
                    end else if (p == "/" && b == "*") begin
                        n_len = r_len + 16'd1; n_mode = S_BCOMM;
                    end else if ((b == "=" && (p == "=" || p == "!" || p == "<" || p == ">"))
                            || ((p == "&" || p == "|" || p == ":") && b == p)) begin
                        t = '0; t.kind = K_OPER; t.c1 = p; t.c2 = b;
                        toks[cnt] = t; cnt = cnt + 2'd1;
                        n_len = r_len + 16'd1; n_mode = S_IDLE;
                    end else begin
                        t = '0; t.kind = K_OPER; t.c1 = p;
                        toks[cnt] = t; cnt = cnt + 2'd1; fresh = 1'b1;
                    end
                end
                S_LCOMM: if (b == 8'h0A) n_mode = S_IDLE;
                S_BCOMM: begin
                    n_len = (r_len == 16'hFFFF) ? r_len : r_len + 16'd1;
                    if (b == "*") n_mode = S_BSTAR;
                end
                S_BSTAR: begin
                    n_len = (r_len == 16'hFFFF) ? r_len : r_len + 16'd1;
                    if (b == "/") n_mode = S_IDLE;
                    else if (b != "*") n_mode = S_BCOMM;
                end
                S_STR, S_CHR: begin
                    n_len = (r_len == 16'hFFFF) ? r_len : r_len + 16'd1;
                    if (b == ((r_mode == S_STR) ? 8'h22 : 8'h27)) begin
                        t = '0; t.kind = (r_mode == S_STR) ? K_STR : K_CHR;
                        toks[cnt] = t; cnt = cnt + 2'd1; n_mode = S_IDLE;
                    end else if (b == 8'h5C) n_mode = (r_mode == S_STR) ? S_STRESC : S_CHRESC;
                end
                S_STRESC: begin
                    n_len = (r_len == 16'hFFFF) ? r_len : r_len + 16'd1; n_mode = S_STR;
                end
                S_CHRESC: begin
                    n_len = (r_len == 16'hFFFF) ? r_len : r_len + 16'd1; n_mode = S_CHR;
                end
                default: fresh = 1'b1;
            endcase
            // Stamp positions on tokens closed by this byte (old start).
            for (int k = 0; k < 3; k++) begin
                toks[k].line = r_sline; toks[k].col = r_scol;
                toks[k].off = r_soff; toks[k].len = n_len;
            end
            if (fresh) begin
                n_mode = S_IDLE;
                if (!(b == 8'h20 || (b >= 8'd9 && b <= 8'd13))) begin
                    n_sline = r_line; n_scol = r_col; n_soff = r_off; n_len = 16'd1;
                    t = '0; t.line = r_line; t.col = r_col; t.off = r_off; t.len = 16'd1;
                    if (is_dig(b)) n_mode = S_NUM;
                    else if (is_alp(b)) begin
                        name_we = 1'b1; name_idx = '0; n_mode = S_IDENT;
                    end else begin
                        case (b)
                            8'h22: n_mode = S_STR;
                            8'h27: n_mode = S_CHR;
                            "/", "=", "!", "<", ">", "&", "|", ":": begin
                                n_pend = b; n_mode = S_OP;
                            end
                            "+", "-", "*", "%": begin
                                t.kind = K_OPER; t.c1 = b; toks[cnt] = t; cnt = cnt + 2'd1;
                            end
                            "(", ")", "{", "}", "[", "]", ";", ",", ".": begin
                                t.kind = K_DELIM; t.c1 = b; toks[cnt] = t; cnt = cnt + 2'd1;
                            end
                            default: begin
                                t.kind = K_ERROR; t.err = E_UNKNOWN; t.c1 = b;
                                toks[cnt] = t; cnt = cnt + 2'd1; n_mode = S_DEAD;
                            end
                        endcase
                    end
                end
            end
            if (b == 8'h0A) begin
                n_line = r_line + 24'd1; n_col = 16'd1;
            end else if (r_col != 16'hFFFF) n_col = r_col + 16'd1;
            n_off = r_off + 32'd1;
            n_fresh = 1'b0;
        end
        if (i_take && i_eos) begin
            t = '0; t.line = n_sline; t.col = n_scol; t.off = n_soff; t.len = n_len;
            case (n_mode)
                S_NUM: begin t.kind = K_INT; toks[cnt] = t; cnt = cnt + 2'd1; end
                S_BADNUM: begin
                    t.kind = K_ERROR; t.err = E_BADNUM; toks[cnt] = t;
                    cnt = cnt + 2'd1; clean = 1'b0;
                end
                S_IDENT: begin
                    // The name still open here may include this item's byte,
                    // which lands in the buffer only at the coming edge.
                    for (int j = 0; j < KEYWORD_MAX_LEN; j++)
                        nm[j] = (name_we && name_idx == NW'(j)) ? i_byte : r_name[j];
                    for (int i = KW_COUNT - 1; i >= 0; i--) begin
                        m = (16'(kw_len(5'(i))) == n_len);
                        for (int j = 0; j < KEYWORD_MAX_LEN; j++)
                            if (j < KW_TEXT_LEN && 4'(j) < kw_len(5'(i))
                                    && nm[j] != kw_char(5'(i), 4'(j))) m = 1'b0;
                        if (m) hit = 5'(i + 1);
                    end
                    if (hit != 0) begin t.kind = K_KEYWORD; t.kw = hit; end
                    else t.kind = K_IDENT;
                    toks[cnt] = t; cnt = cnt + 2'd1;
                end
                S_OP: begin t.kind = K_OPER; t.c1 = n_pend; toks[cnt] = t; cnt = cnt + 2'd1; end
                S_BCOMM, S_BSTAR: begin
                    t.kind = K_ERROR; t.err = E_OPENCOMM; toks[cnt] = t;
                    cnt = cnt + 2'd1; clean = 1'b0;
                end
                S_STR, S_STRESC: begin
                    t.kind = K_ERROR; t.err = E_OPENSTR; toks[cnt] = t;
                    cnt = cnt + 2'd1; clean = 1'b0;
                end
                S_CHR, S_CHRESC: begin
                    t.kind = K_ERROR; t.err = E_OPENCHR; toks[cnt] = t;
                    cnt = cnt + 2'd1; clean = 1'b0;
                end
                S_DEAD: clean = 1'b0;
                default: ;
            endcase
            if (clean) begin
                t = '0; t.kind = K_END; t.line = n_line; t.col = n_col; t.off = n_off;
                toks[cnt] = t; cnt = cnt + 2'd1;
            end
            n_mode = S_IDLE; n_pend = '0; n_line = n_start; n_col = 16'd1; n_off = '0;
            n_sline = '0; n_scol = 16'd1; n_soff = '0; n_len = '0; n_fresh = 1'b1;
        end
    end

    always_comb begin
        o_group.count = cnt;
        o_group.t0 = toks[0];
        o_group.t1 = toks[1];
        o_group.t2 = toks[2];
        case (cnt)
            2'd1: o_group.t0.last = 1'b1;
            2'd2: o_group.t1.last = 1'b1;
            2'd3: o_group.t2.last = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= S_IDLE; r_pend <= '0; r_start <= 24'd1; r_line <= 24'd1;
            r_col <= 16'd1; r_off <= '0; r_sline <= '0; r_scol <= 16'd1;
            r_soff <= '0; r_len <= '0; r_fresh <= 1'b1;
        end else begin
            r_mode <= n_mode; r_pend <= n_pend; r_start <= n_start; r_line <= n_line;
            r_col <= n_col; r_off <= n_off; r_sline <= n_sline; r_scol <= n_scol;
            r_soff <= n_soff; r_len <= n_len; r_fresh <= n_fresh;
        end
        if (name_we) r_name[name_idx] <= i_byte;
    end
endmodule
`default_nettype wire

/* hw/rtl/sct_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_back
// Two-entry group queue and descriptor sequencer toward the output.
// ----------------------------------------------------------------------------
module sct_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  sct_pkg::t_group    i_group,
    output logic               o_full,
    input  wire logic          i_out_stall,
    output logic               o_valid,
    output sct_pkg::t_token    o_token
);
    import sct_pkg::*;

    t_group     r_q [2];
    logic       r_wp, r_rp, n_wp, n_rp;
    logic [1:0] r_n, n_n;
    logic [1:0] r_sub, n_sub;
    logic       pop, fire;

    assign o_full = (r_n == 2'd2);
    assign o_valid = (r_n != 2'd0);
    always_comb begin
        case (r_sub)
            2'd0: o_token = r_q[r_rp].t0;
            2'd1: o_token = r_q[r_rp].t1;
            default: o_token = r_q[r_rp].t2;
        endcase
    end
    assign fire = o_valid && !i_out_stall;
    assign pop = fire && (r_sub + 2'd1 == r_q[r_rp].count);

    always_comb begin
        n_wp = r_wp; n_rp = r_rp; n_sub = r_sub;
        if (i_push) n_wp = !r_wp;
        if (fire) n_sub = r_sub + 2'd1;
        if (pop) begin n_rp = !r_rp; n_sub = '0; end
        n_n = r_n + {1'b0, i_push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_n <= '0; r_sub <= '0;
        end else begin
            r_wp <= n_wp; r_rp <= n_rp; r_n <= n_n; r_sub <= n_sub;
        end
        if (i_push) r_q[r_wp] <= i_group;
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue overflow");
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> i_group.count != 2'd0) else $error("empty group pushed");
    a_last_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> o_token.last) else $error("group ended without last flag");
`endif
endmodule
`default_nettype wire

/* hw/rtl/source_code_tokenizer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// source_code_tokenizer
// Streaming lexer for a C-like language, one source byte per transfer.
// ----------------------------------------------------------------------------
// The block takes one byte transfer per clock cycle and sends one token
// descriptor per output transfer. The scanner settles all descriptors that a
// byte causes (up to three, for example an identifier, an operator and the end
// token) in the cycle it is taken, and pushes them as a group into a two-entry
// queue; the output side drains a group at one descriptor per cycle while
// i_stall is low. Input stalls only while that queue is full, so the
// sustained rate is one byte per cycle while bytes average at most one token.
// ----------------------------------------------------------------------------
module source_code_tokenizer #(
    parameter int KEYWORD_MAX_LEN = 9
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [23:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_source_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_end_of_source,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [3:0]       o_token_kind,
    output logic [2:0]       o_error_kind,
    output logic [4:0]       o_keyword_index,
    output logic [7:0]       o_first_char,
    output logic [7:0]       o_second_char,
    output logic [23:0]      o_token_line,
    output logic [15:0]      o_token_column,
    output logic [31:0]      o_token_offset,
    output logic [15:0]      o_token_length,
    output logic             o_last_of_run
);
    import sct_pkg::*;

    t_group grp;
    t_token tk;
    logic   full, take;

    // Input is held off only while the queue has no free entry.
    assign o_stall = full;
    assign take = i_valid && !full;

    sct_front #(.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)) u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data, .i_take(take),
        .i_byte(i_source_byte), .i_has(i_has_byte), .i_eos(i_end_of_source),
        .o_group(grp)
    );

    sct_back u_back (
        .i_clk, .i_rst_n, .i_push(take && grp.count != 2'd0), .i_group(grp),
        .o_full(full), .i_out_stall(i_stall), .o_valid, .o_token(tk)
    );

    assign o_token_kind = tk.kind;
    assign o_error_kind = tk.err;
    assign o_keyword_index = tk.kw;
    assign o_first_char = tk.c1;
    assign o_second_char = tk.c2;
    assign o_token_line = tk.line;
    assign o_token_column = tk.col;
    assign o_token_offset = tk.off;
    assign o_token_length = tk.len;
    assign o_last_of_run = tk.last;
endmodule
`default_nettype wire
